FILE: design/hsu_pkg.sv
// Shared types and codes for the sequential Hopfield update block.
// No dependencies.
package hsu_pkg;

   localparam int MAX_NEURONS_DEF = 64;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam logic [2:0] CMD_WR_WEIGHT = 3'd0;
   localparam logic [2:0] CMD_WR_BIT    = 3'd1;
   localparam logic [2:0] CMD_UPDATE    = 3'd2;
   localparam logic [2:0] CMD_SWEEP     = 3'd3;
   localparam logic [2:0] CMD_RD_BIT    = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OOB   = 2'd1;
   localparam logic [1:0] STAT_LIMIT = 2'd2;

   typedef struct packed {
      logic shift;
      logic wr;
      logic wr_val;
      logic snap;
   } hsu_ctl_type;

endpackage

FILE: design/hsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hsu_cell.sv
// One neuron cell: holds the neuron bit and its snapshot, passes the bit on.
// Depends on hsu_pkg.
module hsu_cell
   import hsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  hsu_ctl_type ctl,
   input  logic        sel,
   input  logic        active,
   input  logic        bit_in,
   output logic        bit_out,
   output logic        match
);

   logic bit_ff;
   logic snap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b1;
      end else if (ctl.shift) begin
         bit_ff <= bit_in;
      end else if (ctl.wr && sel) begin
         bit_ff <= ctl.wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.snap) begin
         snap_ff <= bit_ff;
      end
   end

   assign bit_out = bit_ff;
   assign match   = !active || (bit_ff == snap_ff);

endmodule

FILE: design/hsu_chain.sv
// Ring of neuron cells that rotates one place per cycle during an update.
// Depends on hsu_pkg and hsu_cell.
module hsu_chain
   import hsu_pkg::*;
#(
   parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hsu_ctl_type                      ctl,
   input  logic [$clog2(MAX_NEURONS)-1:0]   idx,
   input  logic [$clog2(MAX_NEURONS+1)-1:0] count,
   output logic                             head_bit,
   output logic                             sel_bit,
   output logic                             match_all
);

   localparam int IDX_W = $clog2(MAX_NEURONS);

   logic [MAX_NEURONS-1:0] bits;
   logic [MAX_NEURONS-1:0] match_vec;

   for (genvar k = 0; k < MAX_NEURONS; k++) begin : g_cell
      hsu_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .sel     (idx == IDX_W'(k)),
         .active  (32'(k) < 32'(count)),
         .bit_in  (bits[(k + 1) % MAX_NEURONS]),
         .bit_out (bits[k]),
         .match   (match_vec[k])
      );
   end

   assign head_bit  = bits[0];
   assign sel_bit   = bits[idx];
   assign match_all = &match_vec;

endmodule

FILE: design/hopfield_sequential_update.sv
// Write and read commands go from S_IDLE through S_EXEC and S_RESP to the result
// register; an update runs S_URUN, S_ULAST and S_UWB, reading the weight row one entry
// a cycle. A sweep repeats the update once per step, plus a bit-serial remainder (S_MOD)
// and the leftover steps when a step limit ends an oscillation. One item at a time.
// Reset: neuron bits all ones, active count 64, weights undefined until written.
module hopfield_sequential_update
   import hsu_pkg::*;
#(
   parameter int MAX_NEURONS = MAX_NEURONS_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [5:0]         req_neuron_index,
   input  logic [5:0]         req_column_index,
   input  logic signed [15:0] req_weight_value,
   input  logic               req_bit_value,
   input  logic [31:0]        req_max_steps,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_neuron_value,
   output logic               rsp_changed,
   output logic signed [31:0] rsp_potential,
   output logic               rsp_converged,
   output logic [31:0]        rsp_steps_taken,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_active_neurons
);

   localparam int IDX_W = $clog2(MAX_NEURONS);
   localparam int CNT_W = $clog2(MAX_NEURONS + 1);
   localparam int AD_W  = $clog2(MAX_NEURONS * MAX_NEURONS);
   localparam int AW    = (WEIGHT_BITS + IDX_W + 1 > 33) ? WEIGHT_BITS + IDX_W + 1 : 33;
   localparam int CNT_RST = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;
   localparam logic signed [AW-1:0] POT_MAX = AW'(33'sh0_7fff_ffff);
   localparam logic signed [AW-1:0] POT_MIN = AW'(33'sh1_8000_0000);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_URUN, S_ULAST, S_UWB, S_SWINIT, S_SWCHK, S_MOD, S_EXTRA, S_RESP
   } state_type;

   typedef enum logic [1:0] {MODE_ONE, MODE_SWEEP, MODE_EXTRA} mode_type;

   state_type state_ff;
   mode_type  mode_ff;

   logic [2:0]               cmd_ff;
   logic [5:0]               ni_ff, ci_ff;
   logic signed [15:0]       wv_ff;
   logic                     bv_ff;
   logic [31:0]              ms_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [IDX_W-1:0]         n_ff, t_ff, idx_ff, snap_idx_ff;
   logic                     inc_ff, rdv_ff, ch_ff;
   logic signed [AW-1:0]     acc_ff;
   logic [31:0]              steps_ff, lam_ff, limit_ff, divd_ff;
   logic [32:0]              power_ff, rem_ff;
   logic [CNT_W-1:0]         run_ff;
   logic [4:0]               dcnt_ff;
   logic                     res_nv_ff, res_ch_ff, res_conv_ff;
   logic signed [31:0]       res_pot_ff;
   logic [31:0]              res_steps_ff;
   logic [1:0]               res_status_ff;
   logic                     rsp_valid_ff, rsp_nv_ff, rsp_ch_ff, rsp_conv_ff;
   logic signed [31:0]       rsp_pot_ff;
   logic [31:0]              rsp_steps_ff;
   logic [1:0]               rsp_status_ff;

   logic [31:0]              steps_in, lam_in;
   logic [CNT_W-1:0]         run_in;
   logic [IDX_W-1:0]         idx_in, chain_idx;
   logic [32:0]              rem_sh;
   logic                     oob_n, oob_w, inc_flag, nb, changed, old_bit;
   logic                     head_bit, match_all, conv_now, repeat_now, lam_wrap;
   logic signed [31:0]       pot_sat;
   logic [WEIGHT_BITS-1:0]   rd_data;
   logic [AD_W-1:0]          wr_addr, rd_addr;
   logic                     ram_wr;
   hsu_ctl_type              ctl;

   assign oob_n = 32'(ni_ff) >= 32'(cnt_ff);
   assign oob_w = oob_n || (32'(ci_ff) >= 32'(cnt_ff));

   assign steps_in   = steps_ff + 32'd1;
   assign lam_in     = lam_ff + 32'd1;
   assign run_in     = ch_ff ? '0 : run_ff + CNT_W'(1);
   assign idx_in     = (32'(idx_ff) + 32'd1 >= 32'(cnt_ff)) ? '0 : idx_ff + IDX_W'(1);
   assign conv_now   = 32'(run_in) >= 32'(cnt_ff);
   assign repeat_now = (idx_in == snap_idx_ff) && match_all;
   assign lam_wrap   = {1'b0, lam_in} == power_ff;
   assign rem_sh     = {rem_ff[31:0], divd_ff[31]};

   assign inc_flag = (state_ff == S_URUN) && (32'(t_ff) < 32'(cnt_ff))
                     && ((t_ff == n_ff) || head_bit);

   always_comb begin
      if (acc_ff > POT_MAX) begin
         pot_sat = 32'sh7fff_ffff;
      end else if (acc_ff < POT_MIN) begin
         pot_sat = 32'sh8000_0000;
      end else begin
         pot_sat = acc_ff[31:0];
      end
   end

   assign nb      = (acc_ff != '0) ? !acc_ff[AW-1] : old_bit;
   assign changed = nb != old_bit;

   assign ram_wr  = (state_ff == S_EXEC) && (cmd_ff == CMD_WR_WEIGHT) && !oob_w;
   assign wr_addr = AD_W'(32'(ni_ff) * MAX_NEURONS + 32'(ci_ff));
   assign rd_addr = AD_W'(32'(n_ff) * MAX_NEURONS + 32'(t_ff));

   assign chain_idx  = (state_ff == S_UWB) ? n_ff : IDX_W'(ni_ff);
   assign ctl.shift  = state_ff == S_URUN;
   assign ctl.wr     = (state_ff == S_UWB)
                       || ((state_ff == S_EXEC) && (cmd_ff == CMD_WR_BIT) && !oob_n);
   assign ctl.wr_val = (state_ff == S_UWB) ? nb : bv_ff;
   assign ctl.snap   = (state_ff == S_SWINIT)
                       || ((state_ff == S_SWCHK) && !conv_now && !repeat_now && lam_wrap);

   hsu_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (MAX_NEURONS * MAX_NEURONS)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_addr),
      .wr_data (WEIGHT_BITS'(wv_ff)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hsu_chain #(
      .MAX_NEURONS (MAX_NEURONS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .idx       (chain_idx),
      .count     (cnt_ff),
      .head_bit  (head_bit),
      .sel_bit   (old_bit),
      .match_all (match_all)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         cnt_ff       <= CNT_W'(CNT_RST);
      end else begin
         if (csr_valid) begin
            if (csr_active_neurons == 7'd0) begin
               cnt_ff <= CNT_W'(1);
            end else if (32'(csr_active_neurons) > MAX_NEURONS) begin
               cnt_ff <= CNT_W'(MAX_NEURONS);
            end else begin
               cnt_ff <= CNT_W'(csr_active_neurons);
            end
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rdv_ff <= state_ff == S_URUN;
         inc_ff <= inc_flag;
         if (rdv_ff && inc_ff) begin
            acc_ff <= acc_ff + AW'($signed(rd_data));
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  ni_ff    <= req_neuron_index;
                  ci_ff    <= req_column_index;
                  wv_ff    <= req_weight_value;
                  bv_ff    <= req_bit_value;
                  ms_ff    <= req_max_steps;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_nv_ff     <= 1'b0;
               res_ch_ff     <= 1'b0;
               res_pot_ff    <= '0;
               res_conv_ff   <= 1'b0;
               res_steps_ff  <= '0;
               res_status_ff <= STAT_OK;
               state_ff      <= S_RESP;
               case (cmd_ff)
                  CMD_WR_WEIGHT: begin
                     if (oob_w) begin
                        res_status_ff <= STAT_OOB;
                     end
                  end
                  CMD_WR_BIT, CMD_RD_BIT: begin
                     if (oob_n) begin
                        res_status_ff <= STAT_OOB;
                     end else begin
                        res_nv_ff <= (cmd_ff == CMD_WR_BIT) ? bv_ff : old_bit;
                     end
                  end
                  CMD_UPDATE: begin
                     if (oob_n) begin
                        res_status_ff <= STAT_OOB;
                     end else begin
                        n_ff     <= IDX_W'(ni_ff);
                        mode_ff  <= MODE_ONE;
                        t_ff     <= '0;
                        acc_ff   <= '0;
                        state_ff <= S_URUN;
                     end
                  end
                  CMD_SWEEP: begin
                     state_ff <= S_SWINIT;
                  end
                  default: begin
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_URUN: begin
               t_ff <= t_ff + IDX_W'(1);
               if (32'(t_ff) == MAX_NEURONS - 1) begin
                  state_ff <= S_ULAST;
               end
            end
            S_ULAST: begin
               state_ff <= S_UWB;
            end
            S_UWB: begin
               case (mode_ff)
                  MODE_ONE: begin
                     res_nv_ff  <= nb;
                     res_ch_ff  <= changed;
                     res_pot_ff <= pot_sat;
                     state_ff   <= S_RESP;
                  end
                  MODE_SWEEP: begin
                     ch_ff    <= changed;
                     state_ff <= S_SWCHK;
                  end
                  default: begin
                     idx_ff   <= idx_in;
                     rem_ff   <= rem_ff - 33'd1;
                     state_ff <= S_EXTRA;
                  end
               endcase
            end
            S_SWINIT: begin
               steps_ff    <= '0;
               power_ff    <= 33'd1;
               lam_ff      <= '0;
               idx_ff      <= '0;
               snap_idx_ff <= '0;
               run_ff      <= '0;
               limit_ff    <= (ms_ff != '0) ? ms_ff : 32'hffff_ffff;
               n_ff        <= '0;
               mode_ff     <= MODE_SWEEP;
               t_ff        <= '0;
               acc_ff      <= '0;
               state_ff    <= S_URUN;
            end
            S_SWCHK: begin
               steps_ff <= steps_in;
               run_ff   <= run_in;
               idx_ff   <= idx_in;
               if (conv_now) begin
                  res_conv_ff  <= 1'b1;
                  res_steps_ff <= steps_in;
                  state_ff     <= S_RESP;
               end else if (repeat_now) begin
                  if (ms_ff != '0) begin
                     divd_ff  <= limit_ff - steps_in;
                     rem_ff   <= '0;
                     dcnt_ff  <= '0;
                     lam_ff   <= lam_in;
                     state_ff <= S_MOD;
                  end else begin
                     res_status_ff <= STAT_LIMIT;
                     res_steps_ff  <= steps_in;
                     state_ff      <= S_RESP;
                  end
               end else begin
                  if (lam_wrap) begin
                     snap_idx_ff <= idx_in;
                     power_ff    <= {power_ff[31:0], 1'b0};
                     lam_ff      <= '0;
                  end else begin
                     lam_ff <= lam_in;
                  end
                  if (steps_in < limit_ff) begin
                     n_ff     <= idx_in;
                     t_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= S_URUN;
                  end else begin
                     res_status_ff <= STAT_LIMIT;
                     res_steps_ff  <= steps_in;
                     state_ff      <= S_RESP;
                  end
               end
            end
            S_MOD: begin
               if (rem_sh >= {1'b0, lam_ff}) begin
                  rem_ff <= rem_sh - {1'b0, lam_ff};
               end else begin
                  rem_ff <= rem_sh;
               end
               divd_ff <= {divd_ff[30:0], 1'b0};
               dcnt_ff <= dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd31) begin
                  state_ff <= S_EXTRA;
               end
            end
            S_EXTRA: begin
               if (rem_ff == '0) begin
                  res_status_ff <= STAT_LIMIT;
                  res_steps_ff  <= limit_ff;
                  state_ff      <= S_RESP;
               end else begin
                  n_ff     <= idx_ff;
                  mode_ff  <= MODE_EXTRA;
                  t_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_URUN;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_nv_ff     <= res_nv_ff;
                  rsp_ch_ff     <= res_ch_ff;
                  rsp_pot_ff    <= res_pot_ff;
                  rsp_conv_ff   <= res_conv_ff;
                  rsp_steps_ff  <= res_steps_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = state_ff == S_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neuron_value = rsp_nv_ff;
   assign rsp_changed      = rsp_ch_ff;
   assign rsp_potential    = rsp_pot_ff;
   assign rsp_converged    = rsp_conv_ff;
   assign rsp_steps_taken  = rsp_steps_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted item did not start execution");

   a_conv_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_status == STAT_OK && rsp_steps_taken != '0)
      else $error("converged result with bad status or step count");

   a_changed_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_status == STAT_OK && rsp_steps_taken == '0)
      else $error("changed flag on a result that is no single update");

   a_mod_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> lam_ff != '0)
      else $error("cycle length zero in remainder unit");
`endif

endmodule

FILE: test/hopfield_sequential_update_test.sv
// Self-checking bench for hopfield_sequential_update: a directed table, then random
// phases across several active neuron counts, scored against a behavioural network.
// Depends on hsu_pkg and the block itself.
`timescale 1ns / 1ps

module hopfield_sequential_update_test
   import hsu_pkg::*;
;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0]         cmd;
      logic [5:0]         neuron;
      logic [5:0]         column;
      logic signed [15:0] weight;
      logic               bit_in;
      logic [31:0]        max_steps;
   } hop_cmd_type;

   typedef struct {
      logic               neuron_value;
      logic               changed;
      logic signed [31:0] potential;
      logic               converged;
      logic [31:0]        steps_taken;
      logic [1:0]         status;
   } hop_rsp_type;

   typedef struct {
      bit          is_cfg;
      logic [6:0]  cfg_count;
      hop_cmd_type c;
      bit          typed;
      hop_rsp_type r;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [2:0] req_cmd;
   logic [5:0] req_neuron_index, req_column_index;
   logic signed [15:0] req_weight_value;
   logic req_bit_value;
   logic [31:0] req_max_steps;
   logic rsp_valid, rsp_ready;
   logic rsp_neuron_value, rsp_changed, rsp_converged;
   logic signed [31:0] rsp_potential;
   logic [31:0] rsp_steps_taken;
   logic [1:0] rsp_status;
   logic csr_valid, csr_ready;
   logic [6:0] csr_active_neurons;

   hopfield_sequential_update DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_neuron_index(req_neuron_index), .req_column_index(req_column_index),
      .req_weight_value(req_weight_value), .req_bit_value(req_bit_value),
      .req_max_steps(req_max_steps),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_neuron_value(rsp_neuron_value),
      .rsp_changed(rsp_changed), .rsp_potential(rsp_potential),
      .rsp_converged(rsp_converged), .rsp_steps_taken(rsp_steps_taken),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_active_neurons(csr_active_neurons)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // network mirror
   logic signed [15:0] net_weight[64][64];
   bit                 net_bits[64];
   int                 active_count;

   hop_rsp_type  pending_rsp[$];
   stim_row_type stim_table[$];
   int           mismatches;
   int           next_gap;
   int           burst_left;
   bit           hold_request;
   int           hold_cycles;
   int           ready_tick;

   function automatic int live_count();
      if (active_count == 0) return 1;
      if (active_count > 64) return 64;
      return active_count;
   endfunction

   function automatic bit fire_neuron(int n, int c, output logic signed [31:0] pot);
      longint acc;
      bit     old;
      acc = 0;
      old = net_bits[n];
      for (int i = 0; i < c; i++)
         if (i == n || net_bits[i]) acc += net_weight[n][i];
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      pot = acc[31:0];
      if (acc != 0) net_bits[n] = (acc >= 0);
      return net_bits[n] != old;
   endfunction

   function automatic hop_rsp_type network_step(hop_cmd_type q);
      hop_rsp_type r;
      int c;
      logic signed [31:0] pot;
      longint unsigned limit, steps, power, lam, rem;
      int idx, snap_idx, run;
      bit conv, ch, same;
      bit snap[64];
      r = '{default: '0};
      c = live_count();
      case (q.cmd)
         CMD_WR_WEIGHT: begin
            if (q.neuron >= c || q.column >= c) r.status = STAT_OOB;
            else net_weight[q.neuron][q.column] = q.weight;
         end
         CMD_WR_BIT, CMD_RD_BIT: begin
            if (q.neuron >= c) r.status = STAT_OOB;
            else begin
               if (q.cmd == CMD_WR_BIT) net_bits[q.neuron] = q.bit_in;
               r.neuron_value = net_bits[q.neuron];
            end
         end
         CMD_UPDATE: begin
            if (q.neuron >= c) r.status = STAT_OOB;
            else begin
               r.changed = fire_neuron(q.neuron, c, pot);
               r.neuron_value = net_bits[q.neuron];
               r.potential = pot;
            end
         end
         CMD_SWEEP: begin
            limit = (q.max_steps != 0) ? q.max_steps : 64'hFFFF_FFFF;
            steps = 0; power = 1; lam = 0;
            idx = 0; snap_idx = 0; run = 0; conv = 0;
            snap = net_bits;
            while (steps < limit) begin
               steps++;
               ch = fire_neuron(idx, c, pot);
               run = ch ? 0 : run + 1;
               idx = (idx + 1 >= c) ? 0 : idx + 1;
               if (run >= c) begin
                  conv = 1;
                  break;
               end
               lam++;
               same = (idx == snap_idx);
               for (int i = 0; i < c; i++) if (snap[i] != net_bits[i]) same = 0;
               if (same) begin
                  if (q.max_steps != 0) begin
                     rem = (limit - steps) % lam;
                     for (longint unsigned k = 0; k < rem; k++) begin
                        void'(fire_neuron(idx, c, pot));
                        idx = (idx + 1 >= c) ? 0 : idx + 1;
                     end
                     steps = limit;
                  end
                  break;
               end
               if (lam == power) begin
                  snap = net_bits;
                  snap_idx = idx;
                  power <<= 1;
                  lam = 0;
               end
            end
            r.converged = conv;
            r.steps_taken = steps[31:0];
            r.status = conv ? STAT_OK : STAT_LIMIT;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_cmd(hop_cmd_type q, bit typed, hop_rsp_type typed_rsp);
      hop_rsp_type p;
      if (next_gap > 0) repeat (next_gap) @(posedge clock);
      req_valid        <= 1'b1;
      req_cmd          <= q.cmd;
      req_neuron_index <= q.neuron;
      req_column_index <= q.column;
      req_weight_value <= q.weight;
      req_bit_value    <= q.bit_in;
      req_max_steps    <= q.max_steps;
      do @(posedge clock); while (!req_ready);
      p = network_step(q);
      if (typed) p = typed_rsp;
      pending_rsp = {pending_rsp, p};
      if (burst_left > 0) begin
         burst_left--;
         next_gap = 0;
      end else begin
         burst_left = $urandom_range(0, 20);
         next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (next_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic drain_all();
      if (next_gap == 0) begin
         req_valid <= 1'b0;
         next_gap = 1;
      end
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic set_active(logic [6:0] v);
      drain_all();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_active_neurons <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_count = int'(v);
   endtask

   function automatic hop_cmd_type random_payload();
      hop_cmd_type q;
      q.cmd = 3'($urandom_range(0, 7));
      q.neuron = 6'($urandom);
      q.column = 6'($urandom);
      q.weight = 16'($urandom);
      q.bit_in = 1'($urandom);
      q.max_steps = $urandom;
      return q;
   endfunction

   function automatic hop_cmd_type random_cmd(int c);
      hop_cmd_type q;
      int pick;
      q = random_payload();
      pick = $urandom_range(0, 99);
      if (c < 32 && pick >= 90) return q;
      q.neuron = 6'($urandom_range(0, c - 1));
      q.column = 6'($urandom_range(0, c - 1));
      if ($urandom_range(0, 1)) q.weight = 16'($signed($urandom_range(0, 2047)) - 1024);
      if (c >= 32) begin
         case ($urandom_range(0, 3))
            0: q.cmd = CMD_WR_WEIGHT;
            1: q.cmd = CMD_WR_BIT;
            2: q.cmd = CMD_RD_BIT;
            default: q.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
         endcase
      end else if (pick < 25) q.cmd = CMD_WR_WEIGHT;
      else if (pick < 40) q.cmd = CMD_WR_BIT;
      else if (pick < 65) q.cmd = CMD_UPDATE;
      else if (pick < 80) begin
         q.cmd = CMD_SWEEP;
         q.max_steps = $urandom_range(1, 60);
         if (c <= 5 && $urandom_range(0, 3) == 0) q.max_steps = 0;
         if (c <= 5 && $urandom_range(0, 9) == 0) q.max_steps = 32'hFFFF_FFFF;
      end else q.cmd = CMD_RD_BIT;
      return q;
   endfunction

   function automatic void add_row(hop_cmd_type q, bit typed, hop_rsp_type r);
      stim_row_type s;
      s.is_cfg = 0; s.cfg_count = 0; s.c = q; s.typed = typed; s.r = r;
      stim_table = {stim_table, s};
   endfunction

   function automatic void add_cfg(logic [6:0] v);
      stim_row_type s;
      s = '{default: '0};
      s.is_cfg = 1; s.cfg_count = v;
      stim_table = {stim_table, s};
   endfunction

   function automatic hop_cmd_type mk(logic [2:0] cmd, logic [5:0] n, logic [5:0] col,
                                      logic signed [15:0] w, logic b, logic [31:0] ms);
      hop_cmd_type q;
      q.cmd = cmd; q.neuron = n; q.column = col; q.weight = w; q.bit_in = b;
      q.max_steps = ms;
      return q;
   endfunction

   function automatic hop_rsp_type rsp_of(logic nv, logic [1:0] st);
      hop_rsp_type r;
      r = '{default: '0};
      r.neuron_value = nv;
      r.status = st;
      return r;
   endfunction

   function automatic void build_table();
      hop_rsp_type none;
      none = '{default: '0};
      add_row(mk(CMD_RD_BIT, 0, 0, 0, 0, 0), 1, rsp_of(1, STAT_OK));
      add_row(mk(CMD_RD_BIT, 63, 63, 0, 0, 0), 1, rsp_of(1, STAT_OK));
      add_row(mk(CMD_WR_BIT, 63, 0, 0, 0, 0), 1, rsp_of(0, STAT_OK));
      add_row(mk(CMD_RD_BIT, 63, 0, 0, 1, 0), 1, rsp_of(0, STAT_OK));
      add_row(mk(CMD_WR_WEIGHT, 63, 63, -16'sd32768, 0, 0), 1, none);
      add_row(mk(CMD_WR_WEIGHT, 0, 0, 16'sd32767, 0, 0), 1, none);
      add_row(mk(CMD_SPARE_FIRST, 63, 63, -1, 1, 32'hFFFF_FFFF), 1, none);
      add_row(mk(CMD_SPARE_MID, 63, 63, -1, 1, 32'hFFFF_FFFF), 1, none);
      add_row(mk(CMD_SPARE_LAST, 63, 63, -1, 1, 32'hFFFF_FFFF), 1, none);
      add_cfg(7'd1);
      add_row(mk(CMD_WR_WEIGHT, 1, 0, 5, 0, 0), 1, rsp_of(0, STAT_OOB));
      add_row(mk(CMD_WR_WEIGHT, 0, 1, 5, 0, 0), 1, rsp_of(0, STAT_OOB));
      add_row(mk(CMD_WR_BIT, 1, 0, 0, 1, 0), 1, rsp_of(0, STAT_OOB));
      add_row(mk(CMD_UPDATE, 63, 0, 0, 0, 0), 1, rsp_of(0, STAT_OOB));
      add_row(mk(CMD_RD_BIT, 1, 0, 0, 0, 0), 1, rsp_of(0, STAT_OOB));
      add_row(mk(CMD_UPDATE, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(CMD_WR_WEIGHT, 0, 0, -16'sd32768, 0, 0), 1, none);
      add_row(mk(CMD_UPDATE, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(CMD_SWEEP, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(CMD_WR_WEIGHT, 0, 0, 0, 0, 0), 1, none);
      add_row(mk(CMD_UPDATE, 0, 0, 0, 0, 0), 0, none);
      add_cfg(7'd2);
      add_row(mk(CMD_WR_WEIGHT, 0, 0, 256, 0, 0), 1, none);
      add_row(mk(CMD_WR_WEIGHT, 0, 1, -512, 0, 0), 1, none);
      add_row(mk(CMD_WR_WEIGHT, 1, 0, 512, 0, 0), 1, none);
      add_row(mk(CMD_WR_WEIGHT, 1, 1, -256, 0, 0), 1, none);
      add_row(mk(CMD_SWEEP, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(CMD_SWEEP, 0, 0, 0, 0, 5), 0, none);
   endfunction

   // result scoring
   always @(posedge clock) begin
      hop_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result item");
            mismatches++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_neuron_value !== e.neuron_value) begin
               $error("neuron_value exp %0d got %0d", e.neuron_value, rsp_neuron_value);
               mismatches++;
            end
            if (rsp_changed !== e.changed) begin
               $error("changed exp %0d got %0d", e.changed, rsp_changed);
               mismatches++;
            end
            if (rsp_potential !== e.potential) begin
               $error("potential exp %0d got %0d", e.potential, rsp_potential);
               mismatches++;
            end
            if (rsp_converged !== e.converged) begin
               $error("converged exp %0d got %0d", e.converged, rsp_converged);
               mismatches++;
            end
            if (rsp_steps_taken !== e.steps_taken) begin
               $error("steps_taken exp %0d got %0d", e.steps_taken, rsp_steps_taken);
               mismatches++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               mismatches++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold on request
   initial begin
      rsp_ready <= 1'b0;
      hold_cycles = 0;
      ready_tick = 0;
      forever begin
         @(posedge clock);
         ready_tick++;
         if (hold_request) begin
            hold_request = 0;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (ready_tick[7:6] == 2'd0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int counts[10];
      hop_rsp_type none;
      counts = '{4, 1, 6, 2, 64, 3, 63, 5, 8, 7};
      none = '{default: '0};
      mismatches = 0;
      next_gap = 1;
      burst_left = 0;
      hold_request = 0;
      active_count = 64;
      for (int i = 0; i < 64; i++) net_bits[i] = 1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_WR_WEIGHT;
      req_neuron_index <= '0;
      req_column_index <= '0;
      req_weight_value <= '0;
      req_bit_value <= 1'b0;
      req_max_steps <= '0;
      csr_valid <= 1'b0;
      csr_active_neurons <= 7'd64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_table();
      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) set_active(stim_table[i].cfg_count);
         else send_cmd(stim_table[i].c, stim_table[i].typed, stim_table[i].r);
      end

      foreach (counts[p]) begin
         set_active(7'(counts[p]));
         if (counts[p] < 32)
            for (int r = 0; r < counts[p]; r++)
               for (int k = 0; k < counts[p]; k++)
                  send_cmd(mk(CMD_WR_WEIGHT, 6'(r), 6'(k), 16'($urandom), 1'($urandom),
                              $urandom), 0, none);
         for (int n = 0; n < 62; n++) begin
            if (p == 2 && n == 10) hold_request = 1;
            if (p == 3 && n == 20) drain_all();
            send_cmd(random_cmd(counts[p]), 0, none);
         end
      end

      drain_all();
      repeat (300) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
